[hw/rtl/adtf_pkg.sv]
// ----------------------------------------------------------------------------
// adtf_pkg
// shared widths, register indexes and field types of the depth filter
// ----------------------------------------------------------------------------
package adtf_pkg;
   localparam int FRAME_PIXELS = 524288;
   localparam int DEPTH_BITS = 13;
   localparam int AVG_BITS = DEPTH_BITS + 8;
   localparam int VAR_BITS = 2 * DEPTH_BITS + 8;
   localparam int IDX_BITS = 19;
   localparam int ADDR_BITS = $clog2(FRAME_PIXELS);
   localparam int GAIN_BITS = 17;
   localparam int CSR_IDX_BITS = 2;
   localparam int SQRT_ITERS = AVG_BITS;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);
   localparam logic [GAIN_BITS-1:0] ALPHA_BIAS = GAIN_BITS'(655);

   // csr register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_GAIN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOW_GAIN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_DEPTH = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DEPTH = 2'd3;

   typedef struct packed {
      logic [IDX_BITS-1:0]   pixel_index;
      logic [DEPTH_BITS-1:0] depth_in;
      logic                  first_frame;
   } req_type;

   typedef struct packed {
      logic                  valid_mask;
      logic [AVG_BITS-1:0]   filtered_depth;
      logic [AVG_BITS-1:0]   fast_average;
      logic [AVG_BITS-1:0]   slow_average;
      logic [VAR_BITS-1:0]   fast_variance;
      logic [VAR_BITS-1:0]   slow_variance;
      logic [AVG_BITS-1:0]   fast_std;
      logic [AVG_BITS-1:0]   slow_std;
      logic [GAIN_BITS-1:0]  blend_alpha;
   } rsp_type;

   // one pixel's stored state
   typedef struct packed {
      logic [AVG_BITS-1:0] fa;
      logic [AVG_BITS-1:0] sa;
      logic [AVG_BITS-1:0] fl;
      logic [VAR_BITS-1:0] fv;
      logic [VAR_BITS-1:0] sv;
   } entry_type;

   // write back request to the pixel store
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      entry_type            data;
   } wr_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]  fast_gain;
      logic [GAIN_BITS-1:0]  slow_gain;
      logic [DEPTH_BITS-1:0] min_depth;
      logic [DEPTH_BITS-1:0] max_depth;
   } cfg_type;

   // exponential blend, 34 bit values, gain saturated to one
   function automatic logic [VAR_BITS-1:0] blend_term(
      input logic [VAR_BITS-1:0] old, input logic [VAR_BITS-1:0] x,
      input logic [GAIN_BITS-1:0] g);
      logic [GAIN_BITS-1:0] gs;
      logic [VAR_BITS+GAIN_BITS:0] acc;
      gs = (g > GAIN_ONE) ? GAIN_ONE : g;
      acc = (VAR_BITS+GAIN_BITS+1)'(old) * (VAR_BITS+GAIN_BITS+1)'(GAIN_ONE - gs)
          + (VAR_BITS+GAIN_BITS+1)'(x) * (VAR_BITS+GAIN_BITS+1)'(gs)
          + (VAR_BITS+GAIN_BITS+1)'(32768);
      return acc[VAR_BITS+15:16];
   endfunction
endpackage

[hw/rtl/adtf_if.sv]
// ----------------------------------------------------------------------------
// adtf_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface adtf_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/adtf_store.sv]
// ----------------------------------------------------------------------------
// adtf_store
// pixel state memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module adtf_store
   import adtf_pkg::*;
(
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output entry_type            rd_data,
   input  wr_type               wr
);
   entry_type mem [FRAME_PIXELS];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[hw/rtl/adtf_sqrt.sv]
// ----------------------------------------------------------------------------
// adtf_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module adtf_sqrt
   import adtf_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [VAR_BITS-1:0] var_in,
   output logic [AVG_BITS-1:0] root
);
   localparam int RAD_BITS = VAR_BITS + 8;
   localparam int REM_BITS = AVG_BITS + 2;

   logic [RAD_BITS-1:0] rad_ff [1:SQRT_ITERS];
   logic [REM_BITS-1:0] rem_ff [1:SQRT_ITERS];
   logic [AVG_BITS-1:0] res_ff [1:SQRT_ITERS];

   // digit recurrence stages, two radicand bits each
   for (genvar i = 0; i < SQRT_ITERS; i++) begin : g_stage
      logic [RAD_BITS-1:0] rad_cur;
      logic [REM_BITS-1:0] rem_cur;
      logic [AVG_BITS-1:0] res_cur;
      logic [REM_BITS-1:0] cur_in;
      logic [REM_BITS-1:0] trial_in;
      // stage input: the radicand itself or the previous stage
      if (i == 0) begin : g_head
         assign rad_cur = {var_in, 8'd0};
         assign rem_cur = '0;
         assign res_cur = '0;
      end else begin : g_tail
         assign rad_cur = rad_ff[i];
         assign rem_cur = rem_ff[i];
         assign res_cur = res_ff[i];
      end
      always_comb begin
         cur_in = {rem_cur[REM_BITS-3:0], rad_cur[RAD_BITS-1 -: 2]};
         trial_in = {res_cur, 2'b01};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i+1] <= {rad_cur[RAD_BITS-3:0], 2'b00};
            if (cur_in >= trial_in) begin
               rem_ff[i+1] <= cur_in - trial_in;
               res_ff[i+1] <= {res_cur[AVG_BITS-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= cur_in;
               res_ff[i+1] <= {res_cur[AVG_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign root = res_ff[SQRT_ITERS];
endmodule

[hw/rtl/adaptive_depth_temporal_filter.sv]
// ----------------------------------------------------------------------------
// adaptive_depth_temporal_filter
// per-pixel adaptive moving average filter for depth streams
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled and returns one response per
// request in order. Each request reads its pixel entry from a single memory,
// runs the average, variance, square root and blend steps down a fixed
// pipeline and writes the entry back; the pipeline holds the 21-stage square
// root plus capture, average, square, variance and alpha stages and the
// output register.
// Back-to-back requests to the same pixel are caught by comparing with all
// in-range requests in flight; the input then stalls until the earlier write
// lands.
// The whole pipeline advances only when the output register can move.
// Stores are undefined after reset until each pixel sees its first frame.
module adaptive_depth_temporal_filter
   import adtf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   adtf_if.sink                    req,
   adtf_if.source                  rsp,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [GAIN_BITS-1:0]    csr_data
);
   // pipeline depth: p0 read, p1 avgs, p2 squares, p3 variances,
   // sqrt stages, p4 alpha (the p5 filtered blend feeds the output register)
   localparam int NST = SQRT_ITERS + 5;

   // per-stage item context
   typedef struct packed {
      logic                 in_range;
      logic                 first;
      logic                 valid;
      logic [ADDR_BITS-1:0] addr;
      logic [AVG_BITS-1:0]  s;
      entry_type            e;
      logic [VAR_BITS-1:0]  fdev;
      logic [VAR_BITS-1:0]  sdev;
      logic [GAIN_BITS-1:0] alpha;
   } ctx_type;

   cfg_type   cfg_ff;
   ctx_type   ctx_ff [NST];
   ctx_type   ctx_in [NST];
   logic [NST-1:0] vld_ff;
   logic      adv;
   logic      hazard;
   logic      take;
   entry_type rd_data;
   wr_type    wr;
   logic [AVG_BITS-1:0] fstd;
   logic [AVG_BITS-1:0] sstd;
   ctx_type   lst;
   logic [AVG_BITS-1:0] fl_new;
   rsp_type   out_ff;
   logic      out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_gain <= GAIN_BITS'(58982);
         cfg_ff.slow_gain <= GAIN_BITS'(6554);
         cfg_ff.min_depth <= '0;
         cfg_ff.max_depth <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FAST_GAIN: cfg_ff.fast_gain <= csr_data;
            CSR_SLOW_GAIN: cfg_ff.slow_gain <= csr_data;
            CSR_MIN_DEPTH: cfg_ff.min_depth <= csr_data[DEPTH_BITS-1:0];
            CSR_MAX_DEPTH: cfg_ff.max_depth <= csr_data[DEPTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign adv = !out_vld_ff || rsp.ready;

   // same-pixel interlock over all in-range requests in flight
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < NST; i++) begin
         if (vld_ff[i] && ctx_ff[i].in_range
             && ctx_ff[i].addr == req.payload.pixel_index[ADDR_BITS-1:0]) begin
            hazard = 1'b1;
         end
      end
   end

   assign req.ready = adv && !hazard;
   assign take = req.valid && req.ready;

   adtf_store u_store (
      .clock  (clock),
      .rd_en  (adv),
      .rd_addr(req.payload.pixel_index[ADDR_BITS-1:0]),
      .rd_data(rd_data),
      .wr     (wr)
   );

   // next value of every pipeline stage
   always_comb begin
      entry_type e1;
      logic [AVG_BITS-1:0] df;
      logic [AVG_BITS-1:0] ds;
      logic [2*AVG_BITS-1:0] pf;
      logic [2*AVG_BITS-1:0] ps;
      logic [AVG_BITS+8:0] num;
      logic [AVG_BITS+8:0] q;
      logic [AVG_BITS+9:0] a;
      // stage 0: capture request while memory reads
      ctx_in[0] = '0;
      ctx_in[0].in_range = 32'(req.payload.pixel_index) < FRAME_PIXELS;
      ctx_in[0].first = req.payload.first_frame;
      ctx_in[0].valid = req.payload.depth_in >= cfg_ff.min_depth
                        && req.payload.depth_in <= cfg_ff.max_depth;
      ctx_in[0].addr = req.payload.pixel_index[ADDR_BITS-1:0];
      ctx_in[0].s = {req.payload.depth_in, 8'd0};
      // stage 1: averages
      e1 = ctx_ff[0].in_range ? rd_data : '0;
      ctx_in[1] = ctx_ff[0];
      ctx_in[1].e = e1;
      if (ctx_ff[0].first) begin
         ctx_in[1].e.fa = ctx_ff[0].valid ? ctx_ff[0].s : '0;
         ctx_in[1].e.sa = ctx_ff[0].valid ? ctx_ff[0].s : '0;
         ctx_in[1].e.fl = ctx_ff[0].valid ? ctx_ff[0].s : '0;
         ctx_in[1].e.fv = '0;
         ctx_in[1].e.sv = '0;
      end else if (ctx_ff[0].valid) begin
         ctx_in[1].e.fa = AVG_BITS'(blend_term(VAR_BITS'(e1.fa),
            VAR_BITS'(ctx_ff[0].s), cfg_ff.fast_gain));
         ctx_in[1].e.sa = AVG_BITS'(blend_term(VAR_BITS'(e1.sa),
            VAR_BITS'(ctx_ff[0].s), cfg_ff.slow_gain));
      end
      // stage 2: squared deviations
      ctx_in[2] = ctx_ff[1];
      df = ctx_ff[1].s >= ctx_ff[1].e.fa ? ctx_ff[1].s - ctx_ff[1].e.fa
                                         : ctx_ff[1].e.fa - ctx_ff[1].s;
      ds = ctx_ff[1].s >= ctx_ff[1].e.sa ? ctx_ff[1].s - ctx_ff[1].e.sa
                                         : ctx_ff[1].e.sa - ctx_ff[1].s;
      pf = df * df + (2*AVG_BITS)'(128);
      ps = ds * ds + (2*AVG_BITS)'(128);
      ctx_in[2].fdev = pf[VAR_BITS+7:8];
      ctx_in[2].sdev = ps[VAR_BITS+7:8];
      // stage 3: variances
      ctx_in[3] = ctx_ff[2];
      if (!ctx_ff[2].first && ctx_ff[2].valid) begin
         ctx_in[3].e.fv = blend_term(ctx_ff[2].e.fv, ctx_ff[2].fdev, cfg_ff.fast_gain);
         ctx_in[3].e.sv = blend_term(ctx_ff[2].e.sv, ctx_ff[2].sdev, cfg_ff.slow_gain);
      end
      // sqrt delay line
      for (int i = 4; i < NST - 1; i++) ctx_in[i] = ctx_ff[i-1];
      // alpha: (std*256+20)/40 + 655, reciprocal of 40 is exact for 30 bit numerators
      ctx_in[NST-1] = ctx_ff[NST-2];
      num = (AVG_BITS+9)'({sstd, 8'd0}) + (AVG_BITS+9)'(20);
      q = (AVG_BITS+9)'((64'(num) * 64'd3435973837) >> 37);
      a = (AVG_BITS+10)'(q) + (AVG_BITS+10)'(ALPHA_BIAS);
      if (ctx_ff[NST-2].first) begin
         ctx_in[NST-1].alpha = '0;
         ctx_in[NST-1].fdev = '0;
         ctx_in[NST-1].sdev = '0;
      end else begin
         ctx_in[NST-1].alpha = a > (AVG_BITS+10)'(GAIN_ONE) ? GAIN_ONE : GAIN_BITS'(a);
         ctx_in[NST-1].fdev = VAR_BITS'(fstd);
         ctx_in[NST-1].sdev = VAR_BITS'(sstd);
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) ctx_ff[i] <= ctx_in[i];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], take};
      end
   end

   // std pipelines run in lockstep with the delay line
   adtf_sqrt u_fsqrt (.clock(clock), .en(adv), .var_in(ctx_ff[3].e.fv), .root(fstd));
   adtf_sqrt u_ssqrt (.clock(clock), .en(adv), .var_in(ctx_ff[3].e.sv), .root(sstd));

   // final stage: filtered blend, write back, output register
   always_comb begin
      lst = ctx_ff[NST-1];
      fl_new = lst.e.fl;
      if (!lst.first && lst.valid) begin
         fl_new = AVG_BITS'(blend_term(VAR_BITS'(lst.e.fl), VAR_BITS'(lst.s), lst.alpha));
      end
      wr.en = adv && vld_ff[NST-1] && lst.in_range && (lst.first || lst.valid);
      wr.addr = lst.addr;
      wr.data = lst.e;
      wr.data.fl = fl_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.valid_mask <= lst.valid;
         out_ff.filtered_depth <= fl_new;
         out_ff.fast_average <= lst.e.fa;
         out_ff.slow_average <= lst.e.sa;
         out_ff.fast_variance <= lst.e.fv;
         out_ff.slow_variance <= lst.e.sv;
         out_ff.fast_std <= lst.fdev[AVG_BITS-1:0];
         out_ff.slow_std <= lst.sdev[AVG_BITS-1:0];
         out_ff.blend_alpha <= lst.alpha;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;

   // no write while the pipeline is stalled
   a_wr_adv: assert property (@(posedge clock) disable iff (reset) wr.en |-> adv)
      else $error("write back while stalled");
   // never accept a pixel already in flight
   a_no_hazard: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !hazard)
      else $error("same pixel accepted twice");
   // a held response stays held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.payload))
      else $error("response dropped");
endmodule

[tb/sv/tb_adaptive_depth_temporal_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_depth_temporal_filter
// self-checking bench for the adaptive per-pixel depth filter
// ----------------------------------------------------------------------------
// Drives depth pixels over the request channel with random gaps and back
// pressure. A behavioral filter model keeps its own pixel stores and register
// copy and predicts every response. Responses are checked field by field in
// order. Registers are only rewritten once the pipeline has drained.
module tb_adaptive_depth_temporal_filter
   import adtf_pkg::*;
;
   localparam int POOL_SIZE = 48;
   localparam int DRAIN_CYCLES = 40;

   // per pixel state of the behavioral model
   typedef struct {
      bit [63:0] fa;
      bit [63:0] sa;
      bit [63:0] fl;
      bit [63:0] fv;
      bit [63:0] sv;
   } pixel_state_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [GAIN_BITS-1:0] csr_data;

   adtf_if #(.PAYLOAD_TYPE(req_type)) req_if ();
   adtf_if #(.PAYLOAD_TYPE(rsp_type)) rsp_if ();

   adaptive_depth_temporal_filter u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // model copies of stores and registers
   pixel_state_type pixel_store[int unsigned];
   bit [63:0] model_fast_gain;
   bit [63:0] model_slow_gain;
   bit [63:0] model_min_depth;
   bit [63:0] model_max_depth;

   rsp_type expected_pixels[$];
   int error_count;
   bit no_gaps;
   bit [18:0] pool_index[POOL_SIZE];
   bit [12:0] pool_base[POOL_SIZE];

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // exponential blend with gain saturation
   function automatic bit [63:0] ema_step(bit [63:0] old, bit [63:0] x, bit [63:0] g);
      bit [63:0] gs;
      gs = (g > 64'd65536) ? 64'd65536 : g;
      return (old * (64'd65536 - gs) + x * gs + 64'd32768) >> 16;
   endfunction

   function automatic bit [63:0] squared_dev(bit [63:0] s, bit [63:0] avg);
      bit [63:0] d;
      d = (s >= avg) ? s - avg : avg - s;
      return ((d * d + 64'd128) >> 8) & ((64'd1 << VAR_BITS) - 1);
   endfunction

   // integer square root of var << 8, giving Q13.8
   function automatic bit [63:0] std_dev(bit [63:0] var_q);
      bit [63:0] v;
      bit [63:0] root;
      bit [63:0] one;
      v = (var_q & ((64'd1 << VAR_BITS) - 1)) << 8;
      root = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= root + one) begin
            v = v - (root + one);
            root = (root >> 1) + one;
         end else begin
            root = root >> 1;
         end
         one = one >> 2;
      end
      return root & ((64'd1 << AVG_BITS) - 1);
   endfunction

   // predict the response of one accepted pixel and update the model stores
   task automatic predict_pixel(bit [18:0] idx, bit [12:0] depth, bit first);
      pixel_state_type st;
      rsp_type r;
      bit valid;
      bit [63:0] s;
      bit [63:0] fstd;
      bit [63:0] sstd;
      bit [63:0] alpha;
      bit [63:0] amask;
      bit [63:0] vmask;
      amask = (64'd1 << AVG_BITS) - 1;
      vmask = (64'd1 << VAR_BITS) - 1;
      valid = (depth >= model_min_depth) && (depth <= model_max_depth);
      s = 64'(depth) << 8;
      fstd = 0;
      sstd = 0;
      alpha = 0;
      if (pixel_store.exists(idx)) begin
         st = pixel_store[idx];
      end else begin
         st.fa = 0;
         st.sa = 0;
         st.fl = 0;
         st.fv = 0;
         st.sv = 0;
      end
      if (first) begin
         st.fa = valid ? s : 0;
         st.sa = st.fa;
         st.fl = st.fa;
         st.fv = 0;
         st.sv = 0;
      end else begin
         if (valid) begin
            st.fa = ema_step(st.fa, s, model_fast_gain) & amask;
            st.sa = ema_step(st.sa, s, model_slow_gain) & amask;
            st.sv = ema_step(st.sv, squared_dev(s, st.sa), model_slow_gain) & vmask;
            st.fv = ema_step(st.fv, squared_dev(s, st.fa), model_fast_gain) & vmask;
         end
         fstd = std_dev(st.fv);
         sstd = std_dev(st.sv);
         alpha = (sstd * 256 + 20) / 40 + 64'd655;
         if (alpha > 64'd65536) alpha = 64'd65536;
         if (valid) st.fl = ema_step(st.fl, s, alpha) & amask;
      end
      if (first || valid) pixel_store[idx] = st;
      r.valid_mask = valid;
      r.filtered_depth = st.fl[AVG_BITS-1:0];
      r.fast_average = st.fa[AVG_BITS-1:0];
      r.slow_average = st.sa[AVG_BITS-1:0];
      r.fast_variance = st.fv[VAR_BITS-1:0];
      r.slow_variance = st.sv[VAR_BITS-1:0];
      r.fast_std = fstd[AVG_BITS-1:0];
      r.slow_std = sstd[AVG_BITS-1:0];
      r.blend_alpha = alpha[GAIN_BITS-1:0];
      expected_pixels.push_back(r);
   endtask

   // send one request, predicting its response once accepted
   task automatic send_pixel(bit [18:0] idx, bit [12:0] depth, bit first);
      int gap;
      req_type r;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.pixel_index = idx;
      r.depth_in = depth;
      r.first_frame = first;
      req_if.payload <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_pixel(idx, depth, first);
   endtask

   // stop sending and wait until every response is back
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable afterwards
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] index, logic [GAIN_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         CSR_FAST_GAIN: model_fast_gain = 64'(data);
         CSR_SLOW_GAIN: model_slow_gain = 64'(data);
         CSR_MIN_DEPTH: model_min_depth = 64'(data[DEPTH_BITS-1:0]);
         CSR_MAX_DEPTH: model_max_depth = 64'(data[DEPTH_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_config(bit [16:0] fg, bit [16:0] sg, bit [12:0] lo, bit [12:0] hi);
      drain_pipeline();
      write_csr(CSR_FAST_GAIN, fg);
      write_csr(CSR_SLOW_GAIN, sg);
      write_csr(CSR_MIN_DEPTH, 17'(lo));
      write_csr(CSR_MAX_DEPTH, 17'(hi));
      csr_write <= 1'b0;
   endtask

   // directed corner cases
   task automatic test_directed();
      send_pixel(19'd0, 13'd0, 1'b1);
      send_pixel(19'h7FFFF, 13'h1FFF, 1'b1);
      send_pixel(19'd0, 13'h1FFF, 1'b0);
      send_pixel(19'h7FFFF, 13'd0, 1'b0);
      send_pixel(19'd0, 13'h1FFF, 1'b0);
      send_pixel(19'h7FFFF, 13'h1FFF, 1'b0);
      // narrow window: invalid first frame stores zeros, invalid pixels hold
      set_config(17'd58982, 17'd6554, 13'd100, 13'd200);
      send_pixel(19'h2AAAA, 13'd99, 1'b1);
      send_pixel(19'h55555, 13'd100, 1'b1);
      send_pixel(19'h2AAAA, 13'd201, 1'b0);
      send_pixel(19'h55555, 13'd200, 1'b0);
      send_pixel(19'h55555, 13'd300, 1'b0);
      send_pixel(19'h2AAAA, 13'd150, 1'b0);
      // zero gain holds, gain above one saturates
      set_config(17'd0, 17'h1FFFF, 13'd0, 13'h1FFF);
      send_pixel(19'h55555, 13'd4000, 1'b0);
      send_pixel(19'h55555, 13'd10, 1'b0);
      send_pixel(19'd0, 13'd7000, 1'b0);
      // gains at one and at the smallest step
      set_config(17'd65536, 17'd1, 13'd0, 13'h1FFF);
      send_pixel(19'd0, 13'd5, 1'b0);
      send_pixel(19'h7FFFF, 13'd8000, 1'b0);
      send_pixel(19'h2AAAA, 13'd3000, 1'b0);
      // empty window: nothing valid
      set_config(17'd58982, 17'd6554, 13'h1FFF, 13'd0);
      send_pixel(19'd0, 13'd4096, 1'b0);
      send_pixel(19'h7FFFF, 13'h1FFF, 1'b1);
   endtask

   // initialize a pool of pixels so every later read hits a written entry
   task automatic test_first_frames();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_base[i] = 13'($urandom_range(0, 8191));
         send_pixel(pool_index[i], pool_base[i], 1'b1);
      end
   endtask

   // mostly steady pixels with noise, some outliers, jumps and new frames
   task automatic test_random_stream(int count);
      int k;
      int pick;
      int d;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, POOL_SIZE - 1);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            d = $urandom_range(0, 8191);
         end else if (pick < 11) begin
            pool_base[k] = 13'($urandom_range(0, 8191));
            d = int'(pool_base[k]);
         end else begin
            d = int'(pool_base[k]) + int'($urandom_range(0, 80)) - 40;
            if (d < 0) d = 0;
            if (d > 8191) d = 8191;
         end
         send_pixel(pool_index[k], 13'(d), pick >= 97);
      end
   endtask

   // back to back stream with no sender gaps or sink stalls, then a full pause and a gapped stream
   task automatic test_back_to_back();
      no_gaps = 1'b1;
      test_random_stream(150);
      no_gaps = 1'b0;
      drain_pipeline();
      test_random_stream(50);
   endtask

   // response sink with random stalls
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         a = rsp_if.payload;
         if (expected_pixels.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            e = expected_pixels.pop_front();
            check_field("valid_mask", 64'(e.valid_mask), 64'(a.valid_mask));
            check_field("filtered_depth", 64'(e.filtered_depth), 64'(a.filtered_depth));
            check_field("fast_average", 64'(e.fast_average), 64'(a.fast_average));
            check_field("slow_average", 64'(e.slow_average), 64'(a.slow_average));
            check_field("fast_variance", 64'(e.fast_variance), 64'(a.fast_variance));
            check_field("slow_variance", 64'(e.slow_variance), 64'(a.slow_variance));
            check_field("fast_std", 64'(e.fast_std), 64'(a.fast_std));
            check_field("slow_std", 64'(e.slow_std), 64'(a.slow_std));
            check_field("blend_alpha", 64'(e.blend_alpha), 64'(a.blend_alpha));
         end
      end
   end

   // watchdog
   initial begin
      #10000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      error_count = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FAST_GAIN;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      model_fast_gain = 58982;
      model_slow_gain = 6554;
      model_min_depth = 0;
      model_max_depth = 8191;
      pool_index[0] = 19'd0;
      pool_index[1] = 19'h7FFFF;
      for (int i = 2; i < POOL_SIZE; i++) pool_index[i] = 19'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_config(17'd58982, 17'd6554, 13'd0, 13'h1FFF);
      test_first_frames();
      test_random_stream(350);
      set_config(17'd32768, 17'd2000, 13'd500, 13'd7000);
      test_random_stream(250);
      set_config(17'd65536, 17'd65536, 13'd0, 13'h1FFF);
      test_random_stream(150);
      set_config(17'd1, 17'd1, 13'd0, 13'd4095);
      test_random_stream(150);
      set_config(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536)),
                 13'($urandom_range(0, 3000)), 13'($urandom_range(5000, 8191)));
      test_back_to_back();
      drain_pipeline();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/adtf_pkg.sv
hw/rtl/adtf_if.sv
hw/rtl/adtf_store.sv
hw/rtl/adtf_sqrt.sv
hw/rtl/adaptive_depth_temporal_filter.sv
tb/sv/tb_adaptive_depth_temporal_filter.sv
